FILE: sv/ddrw_pkg.sv
// Shared types, codes and reset constants of the differential drive controller.
package ddrw_pkg;

   localparam int DUTY_BITS_DEFAULT = 12;
   localparam int STEP_BITS         = 9;
   localparam int TIME_BITS         = 32;
   localparam int CSR_INDEX_BITS    = 8;
   localparam int CSR_DATA_BITS     = 32;

   localparam int RESET_MAX_DUTY      = 255;
   localparam int RESET_MIN_DUTY      = 100;
   localparam int RESET_STEP_FRACTION = 26;
   localparam int RESET_TIMEOUT_US    = 150000;
   localparam int STEP_FULL           = 256;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DUTY      = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_DUTY      = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_FRACTION = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_US    = 8'd3;

   typedef enum logic {
      KIND_MOVE = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      DIR_NONE     = 3'd0,
      DIR_FORWARD  = 3'd1,
      DIR_BACKWARD = 3'd2,
      DIR_LEFT     = 3'd3,
      DIR_RIGHT    = 3'd4
   } dir_type;

   typedef struct packed {
      kind_type             kind;
      dir_type              direction;
      logic [TIME_BITS-1:0] now_us;
   } request_type;

   typedef struct packed {
      logic [STEP_BITS-1:0] step_fraction;
      logic [TIME_BITS-1:0] timeout_us;
   } timing_cfg_type;

   // Bit 1 is set when the left wheel runs forward, bit 0 for the right wheel.
   function automatic logic [1:0] dir_signs(dir_type dir);
      logic [1:0] signs;
      unique case (dir)
         DIR_FORWARD:  signs = 2'b11;
         DIR_BACKWARD: signs = 2'b00;
         DIR_LEFT:     signs = 2'b01;
         DIR_RIGHT:    signs = 2'b10;
         default:      signs = 2'b11;
      endcase
      return signs;
   endfunction

   function automatic logic dir_valid(dir_type dir);
      return (dir == DIR_FORWARD) || (dir == DIR_BACKWARD) ||
             (dir == DIR_LEFT) || (dir == DIR_RIGHT);
   endfunction

endpackage

FILE: sv/ddrw_csr.sv
// Configuration registers of the differential drive controller.
module ddrw_csr #(
   parameter int DUTY_BITS = ddrw_pkg::DUTY_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [ddrw_pkg::CSR_INDEX_BITS-1:0]  wr_index,
   input  logic [ddrw_pkg::CSR_DATA_BITS-1:0]   wr_data,
   output logic [DUTY_BITS-1:0]                 max_duty,
   output logic [DUTY_BITS-1:0]                 min_duty,
   output ddrw_pkg::timing_cfg_type             timing
);
   import ddrw_pkg::*;

   logic [DUTY_BITS-1:0] max_duty_ff, max_duty_in;
   logic [DUTY_BITS-1:0] min_duty_ff, min_duty_in;
   timing_cfg_type       timing_ff, timing_in;

   always_comb begin
      max_duty_in = max_duty_ff;
      min_duty_in = min_duty_ff;
      timing_in   = timing_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_MAX_DUTY:      max_duty_in = wr_data[DUTY_BITS-1:0];
            CSR_MIN_DUTY:      min_duty_in = wr_data[DUTY_BITS-1:0];
            CSR_STEP_FRACTION: timing_in.step_fraction = wr_data[STEP_BITS-1:0];
            CSR_TIMEOUT_US:    timing_in.timeout_us = wr_data[TIME_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_duty_ff             <= DUTY_BITS'(RESET_MAX_DUTY);
         min_duty_ff             <= DUTY_BITS'(RESET_MIN_DUTY);
         timing_ff.step_fraction <= STEP_BITS'(RESET_STEP_FRACTION);
         timing_ff.timeout_us    <= TIME_BITS'(RESET_TIMEOUT_US);
      end else begin
         max_duty_ff <= max_duty_in;
         min_duty_ff <= min_duty_in;
         timing_ff   <= timing_in;
      end
   end

   assign max_duty = max_duty_ff;
   assign min_duty = min_duty_ff;
   assign timing   = timing_ff;

endmodule

FILE: sv/ddrw_engine.sv
// Drive state, duty ramp, watchdog and PWM level registers.
module ddrw_engine #(
   parameter int DUTY_BITS = ddrw_pkg::DUTY_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  ddrw_pkg::request_type     request,
   input  logic [DUTY_BITS-1:0]      max_duty,
   input  logic [DUTY_BITS-1:0]      min_duty,
   input  ddrw_pkg::timing_cfg_type  timing,
   output logic [DUTY_BITS-1:0]      left_fwd_pwm,
   output logic [DUTY_BITS-1:0]      left_rev_pwm,
   output logic [DUTY_BITS-1:0]      right_fwd_pwm,
   output logic [DUTY_BITS-1:0]      right_rev_pwm,
   output logic                      running
);
   import ddrw_pkg::*;

   localparam int DW = DUTY_BITS + 1;
   localparam int SW = DUTY_BITS + 12;
   localparam int FW = STEP_BITS + 1;

   dir_type                active_dir_ff, active_dir_in;
   logic signed [DW-1:0]   duty_ff [2];
   logic signed [DW-1:0]   duty_in [2];
   logic [TIME_BITS-1:0]   last_move_ff, last_move_in;
   logic [DUTY_BITS-1:0]   level_ff [4];
   logic [DUTY_BITS-1:0]   level_in [4];

   logic [STEP_BITS-1:0]   step_clamped;
   logic signed [FW-1:0]   step_s;
   logic signed [FW-1:0]   step_inv;
   logic signed [DW-1:0]   max_ext;
   logic signed [DW-1:0]   min_ext;
   logic signed [DW-1:0]   target [2];
   logic signed [SW-1:0]   sum [2];
   logic signed [SW-1:0]   sum_adj [2];
   logic signed [DW-1:0]   ramped [2];
   logic [DW-1:0]          mag [2];
   logic [DUTY_BITS-1:0]   mag_clamped [2];
   logic [TIME_BITS-1:0]   elapsed;
   logic [1:0]             signs;

   always_comb begin
      step_clamped = (timing.step_fraction > STEP_BITS'(STEP_FULL)) ?
                     STEP_BITS'(STEP_FULL) : timing.step_fraction;
      step_s   = signed'({1'b0, step_clamped});
      step_inv = signed'(FW'(STEP_FULL) - {1'b0, step_clamped});
      max_ext  = signed'({1'b0, max_duty});
      min_ext  = signed'({1'b0, min_duty});
      elapsed  = request.now_us - last_move_ff;
      signs    = dir_signs(request.direction);

      for (int w = 0; w < 2; w++) begin
         target[w]  = duty_ff[w][DW-1] ? -max_ext : max_ext;
         sum[w]     = SW'(duty_ff[w]) * SW'(step_inv) + SW'(target[w]) * SW'(step_s);
         sum_adj[w] = sum[w][SW-1] ? sum[w] + SW'(255) : sum[w];
         ramped[w]  = DW'(sum_adj[w] >>> 8);
         mag[w]     = ramped[w][DW-1] ? DW'(-ramped[w]) : DW'(ramped[w]);
         mag_clamped[w] = (mag[w] > {1'b0, max_duty}) ? max_duty : mag[w][DUTY_BITS-1:0];
      end

      active_dir_in = active_dir_ff;
      duty_in       = duty_ff;
      last_move_in  = last_move_ff;
      level_in      = level_ff;

      if (request.kind == KIND_MOVE) begin
         last_move_in = request.now_us;
         if (!dir_valid(request.direction)) begin
            active_dir_in = DIR_NONE;
            duty_in       = '{default: '0};
            level_in      = '{default: '0};
         end else if (request.direction != active_dir_ff) begin
            active_dir_in = request.direction;
            for (int w = 0; w < 2; w++) begin
               duty_in[w]      = signs[1-w] ? min_ext : -min_ext;
               level_in[2*w]   = signs[1-w] ? min_duty : '0;
               level_in[2*w+1] = signs[1-w] ? '0 : min_duty;
            end
         end else begin
            for (int w = 0; w < 2; w++) begin
               duty_in[w]      = ramped[w];
               level_in[2*w]   = ramped[w][DW-1] ? '0 : mag_clamped[w];
               level_in[2*w+1] = ramped[w][DW-1] ? mag_clamped[w] : '0;
            end
         end
      end else if (elapsed > timing.timeout_us) begin
         active_dir_in = DIR_NONE;
         duty_in       = '{default: '0};
         level_in      = '{default: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_dir_ff <= DIR_NONE;
         duty_ff       <= '{default: '0};
         last_move_ff  <= '0;
         level_ff      <= '{default: '0};
      end else if (enable) begin
         active_dir_ff <= active_dir_in;
         duty_ff       <= duty_in;
         last_move_ff  <= last_move_in;
         level_ff      <= level_in;
      end
   end

   assign left_fwd_pwm  = level_ff[0];
   assign left_rev_pwm  = level_ff[1];
   assign right_fwd_pwm = level_ff[2];
   assign right_rev_pwm = level_ff[3];
   assign running       = (active_dir_ff != DIR_NONE);

   // A stopped drive shows no level on any channel.
   a_stopped_is_silent: assert property (@(posedge clock) disable iff (reset)
      !running |-> (level_ff[0] == '0) && (level_ff[1] == '0) &&
                   (level_ff[2] == '0) && (level_ff[3] == '0))
      else $error("stopped drive with a non-zero PWM level");

   // At most one channel of each wheel is driven.
   a_one_channel_per_wheel: assert property (@(posedge clock) disable iff (reset)
      ((level_ff[0] == '0) || (level_ff[1] == '0)) &&
      ((level_ff[2] == '0) || (level_ff[3] == '0)))
      else $error("both channels of a wheel driven");

   // A move with no recognised direction always leaves the drive stopped.
   a_bad_direction_stops: assert property (@(posedge clock) disable iff (reset)
      enable && (request.kind == KIND_MOVE) && !dir_valid(request.direction)
      |=> !running)
      else $error("drive still running after a stop command");

endmodule

FILE: sv/diff_drive_ramp_watchdog.sv
// Top level of the differential drive controller: request stage, engine and result handshake.
//
// Each request (a move command or a watchdog tick) produces exactly one response holding the
// four PWM channel levels and the running flag. A request is registered in the request stage on
// acceptance and processed once the response slot is free or being emptied, in a single pass
// through the ramp multipliers and the watchdog compare, so one request per cycle is sustained
// while responses are taken; the result is registered together with the response valid flag in
// the PWM level registers, which themselves form the response
// register; the request stage keeps accepting while a response waits, and only a held response
// together with a full request stage stops new requests. Configuration writes are always
// taken and act on requests processed afterwards.
module diff_drive_ramp_watchdog #(
   parameter int DUTY_BITS = ddrw_pkg::DUTY_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [2:0]                           req_direction,
   input  logic [ddrw_pkg::TIME_BITS-1:0]       req_now_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [DUTY_BITS-1:0]                 rsp_left_fwd_pwm,
   output logic [DUTY_BITS-1:0]                 rsp_left_rev_pwm,
   output logic [DUTY_BITS-1:0]                 rsp_right_fwd_pwm,
   output logic [DUTY_BITS-1:0]                 rsp_right_rev_pwm,
   output logic                                 rsp_running,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ddrw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ddrw_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import ddrw_pkg::*;

   logic                 req_valid_ff, req_valid_in;
   request_type          req_ff, req_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 process;
   logic                 req_take;
   logic [DUTY_BITS-1:0] max_duty;
   logic [DUTY_BITS-1:0] min_duty;
   timing_cfg_type       timing;

   assign process   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || process;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      req_in           = req_ff;
      req_in.kind      = kind_type'(req_kind);
      req_in.direction = dir_type'(req_direction);
      req_in.now_us    = req_now_us;
      req_valid_in     = req_take || (req_valid_ff && !process);
      rsp_valid_in     = process || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
   end

   ddrw_csr #(
      .DUTY_BITS(DUTY_BITS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .max_duty (max_duty),
      .min_duty (min_duty),
      .timing   (timing)
   );

   ddrw_engine #(
      .DUTY_BITS(DUTY_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .enable        (process),
      .request       (req_ff),
      .max_duty      (max_duty),
      .min_duty      (min_duty),
      .timing        (timing),
      .left_fwd_pwm  (rsp_left_fwd_pwm),
      .left_rev_pwm  (rsp_left_rev_pwm),
      .right_fwd_pwm (rsp_right_fwd_pwm),
      .right_rev_pwm (rsp_right_rev_pwm),
      .running       (rsp_running)
   );

   assign rsp_valid = rsp_valid_ff;

   // A request waiting in the input stage keeps its contents until it is processed.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !process |=> req_valid_ff && $stable(req_ff))
      else $error("request stage changed before processing");

   // Processing only happens when the response slot is free or being emptied.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      process |-> !rsp_valid_ff || rsp_ready)
      else $error("unread response overwritten");

   // Processing a request always leaves a response waiting.
   a_process_gives_response: assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_valid_ff)
      else $error("processed request without response");

endmodule

FILE: verif/diff_drive_ramp_watchdog_tb.sv
// Self-checking testbench for the differential drive controller with ramp and watchdog.
module diff_drive_ramp_watchdog_tb;
   import ddrw_pkg::*;

   localparam int DUTY_W = DUTY_BITS_DEFAULT;

   typedef struct packed {
      logic [DUTY_W-1:0] left_fwd;
      logic [DUTY_W-1:0] left_rev;
      logic [DUTY_W-1:0] right_fwd;
      logic [DUTY_W-1:0] right_rev;
      logic              running;
   } pwm_levels_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_kind = 1'b0;
   logic [2:0]                req_direction = 3'd0;
   logic [TIME_BITS-1:0]      req_now_us = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [DUTY_W-1:0]         rsp_left_fwd_pwm;
   logic [DUTY_W-1:0]         rsp_left_rev_pwm;
   logic [DUTY_W-1:0]         rsp_right_fwd_pwm;
   logic [DUTY_W-1:0]         rsp_right_rev_pwm;
   logic                      rsp_running;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Drive state as the controller should hold it.
   logic [DUTY_W-1:0]    cfg_max_duty;
   logic [DUTY_W-1:0]    cfg_min_duty;
   logic [STEP_BITS-1:0] cfg_step;
   logic [TIME_BITS-1:0] cfg_timeout;
   logic [2:0]           active_dir;
   logic signed [12:0]   left_duty;
   logic signed [12:0]   right_duty;
   logic [TIME_BITS-1:0] last_move_us;
   logic [DUTY_W-1:0]    pwm_level [4];

   pwm_levels_type pending_levels [$];
   int          failures = 0;
   int          stall_budget = 0;
   bit          gaps_on = 1'b1;
   logic [2:0]  favoured_dir = DIR_FORWARD;

   diff_drive_ramp_watchdog DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_direction     (req_direction),
      .req_now_us        (req_now_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_fwd_pwm  (rsp_left_fwd_pwm),
      .rsp_left_rev_pwm  (rsp_left_rev_pwm),
      .rsp_right_fwd_pwm (rsp_right_fwd_pwm),
      .rsp_right_rev_pwm (rsp_right_rev_pwm),
      .rsp_running       (rsp_running),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void stop_drive();
      for (int i = 0; i < 4; i++) pwm_level[i] = '0;
      left_duty = '0;
      right_duty = '0;
      active_dir = DIR_NONE;
   endfunction

   function automatic void start_drive(bit left_fwd, bit right_fwd);
      int m;
      m = int'(cfg_min_duty);
      left_duty = left_fwd ? 13'(m) : 13'(-m);
      right_duty = right_fwd ? 13'(m) : 13'(-m);
      pwm_level[0] = left_fwd ? cfg_min_duty : '0;
      pwm_level[1] = left_fwd ? '0 : cfg_min_duty;
      pwm_level[2] = right_fwd ? cfg_min_duty : '0;
      pwm_level[3] = right_fwd ? '0 : cfg_min_duty;
   endfunction

   function automatic logic signed [12:0] ramp_duty(logic signed [12:0] v);
      int s;
      int vi;
      int target;
      int sum;
      vi = int'(v);
      s = (cfg_step > STEP_FULL) ? STEP_FULL : int'(cfg_step);
      target = (vi >= 0) ? int'(cfg_max_duty) : -int'(cfg_max_duty);
      sum = vi * (STEP_FULL - s) + target * s;
      // Integer division truncates toward zero, as the ramp requires.
      return 13'(sum / STEP_FULL);
   endfunction

   function automatic logic [DUTY_W-1:0] duty_magnitude(logic signed [12:0] v);
      int m;
      m = (v < 0) ? -int'(v) : int'(v);
      if (m > int'(cfg_max_duty)) m = int'(cfg_max_duty);
      return m[DUTY_W-1:0];
   endfunction

   function automatic pwm_levels_type next_drive_levels(kind_type kind, logic [2:0] dir,
                                                        logic [TIME_BITS-1:0] now);
      pwm_levels_type lv;
      logic [TIME_BITS-1:0] elapsed;
      if (kind == KIND_MOVE) begin
         last_move_us = now;
         if (dir == DIR_NONE || dir > DIR_RIGHT) begin
            stop_drive();
         end else if (dir != active_dir) begin
            case (dir)
               DIR_FORWARD:  start_drive(1'b1, 1'b1);
               DIR_BACKWARD: start_drive(1'b0, 1'b0);
               DIR_LEFT:     start_drive(1'b0, 1'b1);
               default:      start_drive(1'b1, 1'b0);
            endcase
            active_dir = dir;
         end else begin
            left_duty = ramp_duty(left_duty);
            right_duty = ramp_duty(right_duty);
            pwm_level[0] = (left_duty < 0) ? '0 : duty_magnitude(left_duty);
            pwm_level[1] = (left_duty < 0) ? duty_magnitude(left_duty) : '0;
            pwm_level[2] = (right_duty < 0) ? '0 : duty_magnitude(right_duty);
            pwm_level[3] = (right_duty < 0) ? duty_magnitude(right_duty) : '0;
         end
      end else begin
         elapsed = now - last_move_us;
         if (elapsed > cfg_timeout) stop_drive();
      end
      lv.left_fwd = pwm_level[0];
      lv.left_rev = pwm_level[1];
      lv.right_fwd = pwm_level[2];
      lv.right_rev = pwm_level[3];
      lv.running = (active_dir != DIR_NONE);
      return lv;
   endfunction

   function automatic void compare_field(string name, int expected_value, int actual_value);
      if (expected_value != actual_value) begin
         $error("%s expected %0d actual %0d", name, expected_value, actual_value);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      pwm_levels_type lv;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_levels.size() == 0) begin
            $error("response arrived with no request outstanding");
            failures++;
         end else begin
            lv = pending_levels.pop_front();
            compare_field("left_fwd_pwm", int'(lv.left_fwd), int'(rsp_left_fwd_pwm));
            compare_field("left_rev_pwm", int'(lv.left_rev), int'(rsp_left_rev_pwm));
            compare_field("right_fwd_pwm", int'(lv.right_fwd), int'(rsp_right_fwd_pwm));
            compare_field("right_rev_pwm", int'(lv.right_rev), int'(rsp_right_rev_pwm));
            compare_field("running", int'(lv.running), int'(rsp_running));
         end
      end
      if (stall_budget > 0) begin
         stall_budget = stall_budget - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(gaps_on && $urandom_range(99) < 32);
      end
   end

   task automatic send_request(kind_type kind, logic [2:0] dir, logic [TIME_BITS-1:0] now);
      while (gaps_on && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_direction <= dir;
      req_now_us <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_levels.push_back(next_drive_levels(kind, dir, now));
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_MAX_DUTY:      cfg_max_duty = value[DUTY_W-1:0];
         CSR_MIN_DUTY:      cfg_min_duty = value[DUTY_W-1:0];
         CSR_STEP_FRACTION: cfg_step = value[STEP_BITS-1:0];
         CSR_TIMEOUT_US:    cfg_timeout = value;
         default:           ;
      endcase
   endtask

   task automatic apply_settings(logic [DUTY_W-1:0] max_d, logic [DUTY_W-1:0] min_d,
                                 logic [STEP_BITS-1:0] step, logic [TIME_BITS-1:0] timeout);
      drain_pending();
      write_register(CSR_MAX_DUTY, CSR_DATA_BITS'(max_d));
      write_register(CSR_MIN_DUTY, CSR_DATA_BITS'(min_d));
      write_register(CSR_STEP_FRACTION, CSR_DATA_BITS'(step));
      write_register(CSR_TIMEOUT_US, timeout);
      csr_valid <= 1'b0;
   endtask

   task automatic drive_random_items(int count);
      int pick;
      logic [2:0] dir;
      logic [TIME_BITS-1:0] now;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
               dir = favoured_dir;
            end else if (pick < 90) begin
               favoured_dir = 3'($urandom_range(DIR_FORWARD, DIR_RIGHT));
               dir = favoured_dir;
            end else if (pick < 95) begin
               dir = DIR_NONE;
            end else begin
               dir = 3'($urandom_range(5, 7));
            end
            now = ($urandom_range(99) < 90) ? last_move_us + $urandom_range(3000) : $urandom();
            send_request(KIND_MOVE, dir, now);
         end else begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               now = last_move_us + cfg_timeout + 32'($urandom_range(2)) - 32'd1;
            end else if (pick < 75) begin
               now = last_move_us + 32'($urandom_range(2000));
            end else begin
               now = $urandom();
            end
            send_request(KIND_TICK, 3'($urandom_range(7)), now);
         end
      end
   endtask

   task automatic test_directed_after_reset();
      send_request(KIND_TICK, DIR_NONE, 32'd0);
      send_request(KIND_MOVE, DIR_FORWARD, 32'd10);
      send_request(KIND_MOVE, DIR_FORWARD, 32'd20);
      send_request(KIND_MOVE, DIR_FORWARD, 32'd30);
      // The watchdog compare is strict, so the first tick keeps the drive running.
      send_request(KIND_TICK, DIR_FORWARD, 32'd150030);
      send_request(KIND_TICK, DIR_FORWARD, 32'd150031);
      send_request(KIND_MOVE, DIR_BACKWARD, 32'd200);
      send_request(KIND_MOVE, DIR_BACKWARD, 32'd201);
      send_request(KIND_MOVE, DIR_LEFT, 32'd202);
      send_request(KIND_MOVE, DIR_LEFT, 32'd203);
      send_request(KIND_MOVE, DIR_RIGHT, 32'd204);
      send_request(KIND_MOVE, DIR_RIGHT, 32'd205);
      send_request(KIND_MOVE, DIR_NONE, 32'd206);
      send_request(KIND_MOVE, DIR_NONE, 32'd207);
      send_request(KIND_MOVE, DIR_FORWARD, 32'd208);
      send_request(KIND_MOVE, 3'd5, 32'd209);
      send_request(KIND_MOVE, 3'd6, 32'd210);
      send_request(KIND_MOVE, DIR_LEFT, 32'd211);
      send_request(KIND_MOVE, 3'd7, 32'd212);
      send_request(KIND_TICK, 3'd7, 32'hFFFF_FFFF);
      send_request(KIND_MOVE, DIR_FORWARD, 32'hFFFF_FFF0);
      send_request(KIND_TICK, DIR_NONE, 32'h0000_0010);
      send_request(KIND_TICK, DIR_NONE, 32'hFFFF_FFF0 + 32'd150001);
   endtask

   task automatic test_register_extremes();
      apply_settings(12'd4095, 12'd4095, 9'd256, 32'hFFFF_FFFF);
      drive_random_items(250);
      apply_settings(12'd0, 12'd0, 9'd0, 32'd0);
      drive_random_items(250);
      apply_settings(12'd4095, 12'd0, 9'd511, 32'd1000);
      drive_random_items(250);
      // A start duty above the maximum is applied unclamped, then the ramp clamps it.
      apply_settings(12'd200, 12'd3000, 9'd257, 32'd50);
      drive_random_items(250);
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 3; p++) begin
         apply_settings(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                        9'($urandom_range(300)), 32'($urandom_range(100000)));
         drive_random_items(230);
      end
   endtask

   task automatic test_output_backpressure();
      gaps_on = 1'b0;
      stall_budget = 200;
      drive_random_items(100);
      gaps_on = 1'b1;
   endtask

   task automatic test_continuous_stream();
      apply_settings(12'd255, 12'd100, 9'd26, 32'd150000);
      gaps_on = 1'b0;
      drive_random_items(150);
      gaps_on = 1'b1;
   endtask

   initial begin
      cfg_max_duty = DUTY_W'(RESET_MAX_DUTY);
      cfg_min_duty = DUTY_W'(RESET_MIN_DUTY);
      cfg_step = STEP_BITS'(RESET_STEP_FRACTION);
      cfg_timeout = TIME_BITS'(RESET_TIMEOUT_US);
      last_move_us = '0;
      stop_drive();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_after_reset();
      test_register_extremes();
      test_random_settings();
      test_output_backpressure();
      test_continuous_stream();
      drain_pending();
      repeat (16) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
sv/ddrw_pkg.sv
sv/ddrw_csr.sv
sv/ddrw_engine.sv
sv/diff_drive_ramp_watchdog.sv
verif/diff_drive_ramp_watchdog_tb.sv
